@@ src/rcst_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcst_pkg: shared types and constants of the refcounted slot table
// Item structs, opcode and status codes, table geometry.
// ---------------------------------------------------------------------------
package rcst_pkg;

  // Table geometry
  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ACTIVE_W    = 5;
  localparam int TAG_W       = 31;
  localparam int REF_W       = 16;
  localparam int OPCODE_W    = 3;
  localparam int STATUS_W    = 2;
  localparam int SLOT_OUT_W  = 4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);

  localparam logic signed [REF_W-1:0] REF_MAX = {1'b0, {(REF_W-1){1'b1}}};
  localparam logic signed [REF_W-1:0] REF_MIN = {1'b1, {(REF_W-1){1'b0}}};

  typedef enum logic [OPCODE_W-1:0] {
    OP_ACQUIRE       = 3'd0,
    OP_CLAIM         = 3'd1,
    OP_FREE          = 3'd2,
    OP_CLAIM_ACQUIRE = 3'd3,
    OP_QUERY         = 3'd4,
    OP_DROP          = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_MISS    = 2'd0,
    ST_OK      = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

  // Request item
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [TAG_W-1:0]    frame_index;
  } req_t;

  // Result item
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SLOT_OUT_W-1:0]    slot;
    logic signed [REF_W-1:0]  ref_count;
  } rsp_t;

  // Lookup results handed from the match unit to the table
  typedef struct packed {
    logic                  tag_hit;
    logic [SLOT_IDX_W-1:0] tag_slot;
    logic                  free_hit;
    logic [SLOT_IDX_W-1:0] free_slot;
  } lookup_t;

endpackage

@@ src/rcst_lookup.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcst_lookup: parallel tag match and free-slot search
// Compares the tag against every active valid slot and picks the lowest
// matching slot and the lowest active free slot.
// ---------------------------------------------------------------------------
module rcst_lookup
  import rcst_pkg::*;
(
  input  logic [NUM_SLOTS-1:0]  slot_valid_i,
  input  logic [TAG_W-1:0]      slot_tag_i [NUM_SLOTS],
  input  logic [ACTIVE_W-1:0]   active_slots_i,
  input  logic [TAG_W-1:0]      tag_i,
  output lookup_t               lookup_o
);

  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] match;
  logic [NUM_SLOTS-1:0] free;

  // Per-slot qualifiers; slots at or above active_slots take no part
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      active[i] = (int'(active_slots_i) > i);
      match[i]  = active[i] && slot_valid_i[i] && (slot_tag_i[i] == tag_i);
      free[i]   = active[i] && !slot_valid_i[i];
    end
  end

  // Priority encoders, lowest slot wins
  always_comb begin
    lookup_o = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        lookup_o.tag_hit  = 1'b1;
        lookup_o.tag_slot = SLOT_IDX_W'(i);
      end
      if (free[i]) begin
        lookup_o.free_hit  = 1'b1;
        lookup_o.free_slot = SLOT_IDX_W'(i);
      end
    end
  end

endmodule

@@ src/refcounted_slot_table.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// refcounted_slot_table: buffer pool bookkeeping with reference counts
// Slots are free or tagged with a frame index and carry a signed count.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: an item (opcode, frame index) is taken on a rising edge
//   with start_i high and busy_o low. busy_o stays low, so one item can be
//   given every cycle.
//   Result channel: every item yields one result, shown on rsp_o for exactly
//   one cycle with result_valid_o high. The receiver cannot stall.
//   Pipeline: one input register, one result register; a taken item is
//   held in the first and its result in the second. Throughput is one
//   item per cycle: the tag compare over all slots, the priority encoders and
//   the count update sit in the single stage between the two registers, and
//   the table is updated at the same edge that loads the result, so the next
//   item already sees it.
//   Configuration: cfg_we_i writes active_slots from cfg_wdata_i; write it
//   only while no item is in flight.
//   Reset: every slot free, every count zero, active_slots = 16, nothing in
//   flight. Tags are not reset; they are only read once written.
// ---------------------------------------------------------------------------
module refcounted_slot_table
  import rcst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  req_t                req_i,
  output logic                result_valid_o,
  output rsp_t                rsp_o,
  input  logic                cfg_we_i,
  input  logic [ACTIVE_W-1:0] cfg_wdata_i
);

  logic [ACTIVE_W-1:0]     active_slots_q;
  logic                    req_valid_q;
  req_t                    req_q;
  logic [NUM_SLOTS-1:0]    slot_valid_q;
  logic [TAG_W-1:0]        slot_tag_q  [NUM_SLOTS];
  logic signed [REF_W-1:0] slot_refs_q [NUM_SLOTS];
  logic                    result_valid_q;
  rsp_t                    rsp_q;

  lookup_t                 lookup;
  logic [SLOT_IDX_W-1:0]   sel_slot;
  logic                    sel_hit;
  logic signed [REF_W-1:0] sel_refs;
  logic signed [REF_W-1:0] refs_d;
  logic                    refs_we;
  logic                    claim_we;
  logic                    release_we;
  rsp_t                    rsp_d;

  assign busy_o = 1'b0;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_slots_q <= ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_slots_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
  end

  rcst_lookup u_lookup (
    .slot_valid_i   (slot_valid_q),
    .slot_tag_i     (slot_tag_q),
    .active_slots_i (active_slots_q),
    .tag_i          (req_q.frame_index),
    .lookup_o       (lookup)
  );

  // Operation decode and count update
  always_comb begin
    sel_slot   = lookup.tag_slot;
    sel_hit    = 1'b0;
    refs_we    = 1'b0;
    claim_we   = 1'b0;
    release_we = 1'b0;
    rsp_d      = '0;
    refs_d     = '0;

    unique case (req_q.opcode)
      OP_ACQUIRE, OP_QUERY, OP_DROP, OP_FREE: begin
        sel_slot = lookup.tag_slot;
        sel_hit  = lookup.tag_hit;
      end
      OP_CLAIM, OP_CLAIM_ACQUIRE: begin
        sel_slot = lookup.free_slot;
        sel_hit  = lookup.free_hit;
      end
      default: begin
        sel_hit = 1'b0;
      end
    endcase

    sel_refs = slot_refs_q[sel_slot];
    refs_d   = sel_refs;

    unique case (req_q.opcode)
      OP_ACQUIRE, OP_CLAIM_ACQUIRE: begin
        refs_we = sel_hit;
        if (sel_refs != REF_MAX) begin
          refs_d = sel_refs + REF_W'(1);
        end
      end
      OP_DROP: begin
        refs_we = sel_hit;
        if (sel_refs != REF_MIN) begin
          refs_d = sel_refs - REF_W'(1);
        end
      end
      default: begin
        refs_we = 1'b0;
      end
    endcase

    if (req_q.opcode == OP_CLAIM || req_q.opcode == OP_CLAIM_ACQUIRE) begin
      claim_we = sel_hit;
    end

    // Result on a hit; free only when the count is zero or negative, else refused
    if (sel_hit) begin
      rsp_d.status    = ST_OK;
      rsp_d.slot      = SLOT_OUT_W'(sel_slot);
      rsp_d.ref_count = refs_d;
      if (req_q.opcode == OP_FREE) begin
        if (sel_refs <= 0) begin
          release_we = 1'b1;
        end else begin
          rsp_d.status = ST_REFUSED;
        end
      end
    end
  end

  // Slot state: valid bits and counts are reset, tags are not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_refs_q[i] <= '0;
      end
    end else if (req_valid_q) begin
      if (claim_we) begin
        slot_valid_q[sel_slot] <= 1'b1;
      end
      if (release_we) begin
        slot_valid_q[sel_slot] <= 1'b0;
      end
      if (refs_we) begin
        slot_refs_q[sel_slot] <= refs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q && claim_we) begin
      slot_tag_q[sel_slot] <= req_q.frame_index;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign rsp_o          = rsp_q;

endmodule
